// ===== src/dual_channel_gated_moving_average_unit_assert.svh =====
// Assertion helpers for the gated moving average unit.
// Both macros sample on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef DUAL_CHANNEL_GATED_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define DUAL_CHANNEL_GATED_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DCGMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCGMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dcgma_pkg.sv =====
package dcgma_pkg;

  // Window length of both channels.
  localparam int unsigned WINDOW = 8;

  localparam int unsigned DATA_W = 8;
  // Fill count, able to hold WINDOW itself.
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  // Window sums: WINDOW * 255 always stays below 2**SUM_W.
  localparam int unsigned SUM_W  = DATA_W + CNT_W;
  localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // Divider step counter, one quotient bit per cycle.
  localparam int unsigned STEP_W = $clog2(DATA_W + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GEAR_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANSIENT  = 1'b1;

  localparam logic [DATA_W-1:0] MIN_GEAR_LEVEL_RST = 8'd20;
  localparam logic [DATA_W-1:0] MAX_TRANSIENT_RST  = 8'd10;

  typedef logic [DATA_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Per-word status carried from acceptance to delivery.
  typedef struct packed {
    logic was_batt;
    logic discarded;
    logic restarted;
    logic switched;
    logic next_batt;
  } item_flags_t;

endpackage

// ===== src/dual_channel_gated_moving_average_unit.sv =====
// Dual-channel gated moving average. Each accepted word is one 8-bit converter
// sample. Samples come in sets of WINDOW (package constant, 8), alternating
// between the gear channel and the battery channel, gear first after reset.
// Battery samples land in the battery window by their position in the set and
// the battery average is the window sum over WINDOW. Gear samples at or below
// min_gear_level (register 0, reset 20) are dropped; a kept gear sample that
// differs from the current gear average by more than max_transient (register 1,
// reset 10) first clears the gear ring, then enters it; the gear average is the
// ring sum over the fill count, truncated. Every accepted word yields exactly
// one result word holding both averages and the status flags. The window and
// sum update in the accept cycle, then a bit-serial restoring divider produces
// one quotient bit per cycle, then the result loads the output register once
// that register is free; a dropped gear sample skips the divider. A new word
// is taken only once the previous one has reached the output register.
module dual_channel_gated_moving_average_unit
  import dcgma_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DATA_W-1:0]    adc_value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    gear_average_o,
  output logic [DATA_W-1:0]    battery_average_o,
  output logic                 was_battery_sample_o,
  output logic                 gear_sample_discarded_o,
  output logic                 window_restarted_o,
  output logic                 channel_switched_o,
  output logic                 next_on_battery_o
);

  // Sequencer: wait for a word, or run the divider and hand off the result.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_q, state_d;

  // configuration
  sample_t min_gear_q, max_trans_q;

  // channel bookkeeping
  logic [IDX_W-1:0] set_pos_q;
  logic             on_batt_q;

  // gear ring
  sample_t          gear_win_q [WINDOW];
  sum_t             gear_sum_q, gear_sum_d;
  logic [IDX_W-1:0] gear_slot_q, gear_slot_d;
  logic [CNT_W-1:0] gear_fill_q, gear_fill_d;
  sample_t          gear_avg_q;

  // battery window
  sample_t battery_win_q [WINDOW];
  sum_t    battery_sum_d, battery_sum_q;
  sample_t battery_avg_q;

  // divider: rem_q holds the partial remainder, shift_q shifts the low dividend
  // bits out at the top and the quotient bits in at the bottom
  logic [CNT_W-1:0]  divisor_q, rem_q;
  sample_t           shift_q;
  logic [STEP_W-1:0] step_q;
  logic              div_gear_q, div_batt_q;
  logic [CNT_W:0]    trial;
  logic              trial_ge;
  item_flags_t       flags_q, flags_d;

  // output register
  logic        out_valid_q;
  sample_t     out_gear_q, out_batt_q;
  item_flags_t out_flags_q;

  logic in_acc, out_acc, deliver, last_in_set;
  logic keep_gear, transient;
  sample_t diff;
  sample_t gear_old;
  logic [IDX_W-1:0] gear_base_slot;
  logic [CNT_W-1:0] gear_base_fill;
  sum_t gear_base_sum, div_dividend;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  // hand off once the quotient is complete and the output register is free
  assign deliver     = (state_q == ST_DIV) && (step_q == '0) && (!out_valid_q || !out_stall_i);
  assign last_in_set = (set_pos_q == IDX_W'(WINDOW - 1));

  // Transient check against the average left by the previous kept gear sample.
  always_comb begin
    diff      = (gear_avg_q > adc_value_i) ? (gear_avg_q - adc_value_i)
                                           : (adc_value_i - gear_avg_q);
    keep_gear = !on_batt_q && (adc_value_i > min_gear_q);
    transient = keep_gear && (diff > max_trans_q);
  end

  // Gear ring and battery sum update, divider dividend and flags; a transient starts from an empty ring.
  always_comb begin
    if (transient) begin
      gear_base_sum  = '0;
      gear_base_slot = '0;
      gear_base_fill = '0;
      gear_old       = '0;
    end else begin
      gear_base_sum  = gear_sum_q;
      gear_base_slot = gear_slot_q;
      gear_base_fill = gear_fill_q;
      gear_old       = gear_win_q[gear_slot_q];
    end
    gear_sum_d  = gear_base_sum - {{CNT_W{1'b0}}, gear_old} + {{CNT_W{1'b0}}, adc_value_i};
    gear_slot_d = (gear_base_slot == IDX_W'(WINDOW - 1)) ? '0 : gear_base_slot + 1'b1;
    gear_fill_d = (gear_base_fill == CNT_W'(WINDOW)) ? gear_base_fill
                                                     : gear_base_fill + 1'b1;
    battery_sum_d = battery_sum_q - {{CNT_W{1'b0}}, battery_win_q[set_pos_q]}
                  + {{CNT_W{1'b0}}, adc_value_i};
    div_dividend  = on_batt_q ? battery_sum_d : gear_sum_d;

    flags_d.was_batt  = on_batt_q;
    flags_d.discarded = !on_batt_q && !keep_gear;
    flags_d.restarted = transient;
    flags_d.switched  = last_in_set;
    flags_d.next_batt = on_batt_q ^ last_in_set;
  end

  // One restoring divide step: shift in the next dividend bit, try to subtract.
  always_comb begin
    trial    = {rem_q, shift_q[DATA_W-1]};
    trial_ge = (trial >= {1'b0, divisor_q});
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (deliver) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gear_q  <= MIN_GEAR_LEVEL_RST;
      max_trans_q <= MAX_TRANSIENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_GEAR_LEVEL: min_gear_q  <= cfg_wdata_i;
        CFG_MAX_TRANSIENT:  max_trans_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window state advances in the accept cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_pos_q     <= '0;
      on_batt_q     <= 1'b0;
      gear_sum_q    <= '0;
      gear_slot_q   <= '0;
      gear_fill_q   <= '0;
      battery_sum_q <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        gear_win_q[i]    <= '0;
        battery_win_q[i] <= '0;
      end
    end else if (in_acc) begin
      set_pos_q <= last_in_set ? '0 : set_pos_q + 1'b1;
      on_batt_q <= on_batt_q ^ last_in_set;
      if (on_batt_q) begin
        battery_win_q[set_pos_q] <= adc_value_i;
        battery_sum_q            <= battery_sum_d;
      end else if (keep_gear) begin
        // drop the old ring contents on a transient; the word lands in slot zero
        if (transient) begin
          for (int i = 0; i < WINDOW; i++) begin
            gear_win_q[i] <= (i == 0) ? adc_value_i : '0;
          end
        end else begin
          gear_win_q[gear_slot_q] <= adc_value_i;
        end
        gear_sum_q  <= gear_sum_d;
        gear_slot_q <= gear_slot_d;
        gear_fill_q <= gear_fill_d;
      end
    end
  end

  // Divider: loaded at accept, one quotient bit per cycle after that.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      div_gear_q <= 1'b0;
      div_batt_q <= 1'b0;
    end else if (in_acc) begin
      step_q     <= (on_batt_q || keep_gear) ? STEP_W'(DATA_W) : '0;
      div_gear_q <= keep_gear;
      div_batt_q <= on_batt_q;
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      divisor_q <= on_batt_q ? CNT_W'(WINDOW) : gear_fill_d;
      // the quotient fits in 8 bits, so the top bits are already below the divisor
      rem_q     <= div_dividend[SUM_W-1:DATA_W];
      shift_q   <= div_dividend[DATA_W-1:0];
      flags_q   <= flags_d;
    end else if (step_q != '0) begin
      rem_q   <= trial_ge ? CNT_W'(trial - {1'b0, divisor_q}) : CNT_W'(trial);
      shift_q <= {shift_q[DATA_W-2:0], trial_ge};
    end
  end

  // Held averages; the gear one also feeds the next transient check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_avg_q    <= '0;
      battery_avg_q <= '0;
    end else if (deliver) begin
      if (div_gear_q) gear_avg_q <= shift_q;
      if (div_batt_q) battery_avg_q <= shift_q;
    end
  end

  // Output register: keeps the result while the next word is taken in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (deliver) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      out_gear_q  <= div_gear_q ? shift_q : gear_avg_q;
      out_batt_q  <= div_batt_q ? shift_q : battery_avg_q;
      out_flags_q <= flags_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign gear_average_o          = out_gear_q;
  assign battery_average_o       = out_batt_q;
  assign was_battery_sample_o    = out_flags_q.was_batt;
  assign gear_sample_discarded_o = out_flags_q.discarded;
  assign window_restarted_o      = out_flags_q.restarted;
  assign channel_switched_o      = out_flags_q.switched;
  assign next_on_battery_o       = out_flags_q.next_batt;

`include "dual_channel_gated_moving_average_unit_assert.svh"

  // An accepted word always starts the divide sequence.
  `DCGMA_ASSERT_NEXT(a_accept_starts_div, in_acc, state_q == ST_DIV, "accept did not start divide")
  // The fill count saturates at the window length.
  `DCGMA_ASSERT_IMPL(a_fill_bounded, 1'b1, gear_fill_q <= CNT_W'(WINDOW), "gear fill overflow")
  // A new result only appears after the divide sequence.
  `DCGMA_ASSERT_IMPL(a_result_after_div, $rose(out_valid_o), $past(state_q) == ST_DIV, "result out of sequence")
  // A restart only happens on a kept gear sample.
  `DCGMA_ASSERT_IMPL(a_restart_is_gear, out_valid_o && window_restarted_o, !was_battery_sample_o && !gear_sample_discarded_o, "restart flag on a non-gear word")

endmodule

// ===== dv/dcgma_average_check.sv =====
`timescale 1ns / 100ps

module dcgma_average_check
  import dcgma_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [DATA_W-1:0]    adc_value_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [DATA_W-1:0]    gear_average_i,
  input  logic [DATA_W-1:0]    battery_average_i,
  input  logic                 was_battery_sample_i,
  input  logic                 gear_sample_discarded_i,
  input  logic                 window_restarted_i,
  input  logic                 channel_switched_i,
  input  logic                 next_on_battery_i,
  output int                   pending_o,
  output int                   checked_o,
  output int                   errors_o
);

  typedef struct packed {
    sample_t     gear_avg;
    sample_t     batt_avg;
    item_flags_t flags;
  } averages_t;

  // Register copies.
  sample_t min_level;
  sample_t max_dev;

  // Shadow of the block state.
  logic [CNT_W-1:0] set_count;
  logic             on_batt;
  sample_t          gear_ring [WINDOW];
  sum_t             ring_sum;
  logic [IDX_W-1:0] ring_slot;
  logic [CNT_W-1:0] ring_fill;
  sample_t          batt_ring [WINDOW];

  averages_t expected_averages [$];
  int        errors;
  int        checked;

  function automatic sample_t gear_mean();
    sum_t q;
    if (ring_fill == '0) return '0;
    q = ring_sum / sum_t'(ring_fill);
    return q[DATA_W-1:0];
  endfunction

  function automatic sample_t battery_mean();
    sum_t t;
    t = '0;
    for (int i = 0; i < WINDOW; i++) t = t + sum_t'(batt_ring[i]);
    return sample_t'(t / WINDOW);
  endfunction

  function automatic void clear_gear();
    for (int i = 0; i < WINDOW; i++) gear_ring[i] = '0;
    ring_sum  = '0;
    ring_slot = '0;
    ring_fill = '0;
  endfunction

  function automatic averages_t predict_averages(sample_t v);
    averages_t   r;
    int unsigned pos;
    sample_t     mean;
    sample_t     dev;
    r   = '0;
    pos = set_count % WINDOW;
    r.flags.was_batt = on_batt;
    if (on_batt) begin
      batt_ring[pos] = v;
    end else if (v <= min_level) begin
      r.flags.discarded = 1'b1;
    end else begin
      mean = gear_mean();
      dev  = (mean > v) ? mean - v : v - mean;
      // a jump away from the running mean throws the old gear history away
      if (dev > max_dev) begin
        clear_gear();
        r.flags.restarted = 1'b1;
      end
      ring_sum             = ring_sum - sum_t'(gear_ring[ring_slot]) + sum_t'(v);
      gear_ring[ring_slot] = v;
      ring_slot            = IDX_W'((ring_slot + 1) % WINDOW);
      if (ring_fill < WINDOW) ring_fill = ring_fill + 1'b1;
    end
    if (pos + 1 >= WINDOW) begin
      set_count        = '0;
      on_batt          = ~on_batt;
      r.flags.switched = 1'b1;
    end else begin
      set_count = CNT_W'(pos + 1);
    end
    r.gear_avg        = gear_mean();
    r.batt_avg        = battery_mean();
    r.flags.next_batt = on_batt;
    return r;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("%t mismatch in result %0d, %s: expected %0d, got %0d",
                 $realtime, checked, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    averages_t want;
    if (!rst_ni) begin
      min_level = MIN_GEAR_LEVEL_RST;
      max_dev   = MAX_TRANSIENT_RST;
      set_count = '0;
      on_batt   = 1'b0;
      clear_gear();
      for (int i = 0; i < WINDOW; i++) batt_ring[i] = '0;
      expected_averages.delete();
      errors    = 0;
      checked   = 0;
      pending_o <= 0;
      checked_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MIN_GEAR_LEVEL) min_level = cfg_wdata_i;
        else if (cfg_index_i == CFG_MAX_TRANSIENT) max_dev = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_averages.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t result word with nothing outstanding", $realtime);
        end else begin
          want = expected_averages.pop_front();
          compare_field("gear_average", want.gear_avg, gear_average_i);
          compare_field("battery_average", want.batt_avg, battery_average_i);
          compare_field("was_battery_sample", want.flags.was_batt, was_battery_sample_i);
          compare_field("gear_sample_discarded", want.flags.discarded,
                        gear_sample_discarded_i);
          compare_field("window_restarted", want.flags.restarted, window_restarted_i);
          compare_field("channel_switched", want.flags.switched, channel_switched_i);
          compare_field("next_on_battery", want.flags.next_batt, next_on_battery_i);
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i)
        expected_averages.push_back(predict_averages(adc_value_i));
      pending_o <= expected_averages.size();
      checked_o <= checked;
      errors_o  <= errors;
    end
  end

endmodule

// ===== dv/dual_channel_gated_moving_average_unit_test.sv =====
`timescale 1ns / 100ps

module dual_channel_gated_moving_average_unit_test;
  import dcgma_pkg::*;

  // Upper bound on the whole run.
  localparam int unsigned RUN_LIMIT = 400_000;

  // Directed words, taken under the reset register values (floor 20, limit 10).
  // First gear set: below and at the floor, a first kept word against an empty
  // ring, a deviation of exactly the limit, then jumps that restart the ring.
  // Battery set: both extremes and mid values. Last gear set mixes drops,
  // restarts and slow drift.
  localparam sample_t DIRECTED [24] = '{
    8'd0,   8'd20,  8'd21,  8'd31,  8'd42,  8'd255, 8'd250, 8'd254,
    8'd255, 8'd0,   8'd255, 8'd128, 8'd1,   8'd254, 8'd127, 8'd200,
    8'd19,  8'd21,  8'd255, 8'd128, 8'd138, 8'd149, 8'd20,  8'd255
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_GEAR_LEVEL;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sample_t              adc_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sample_t              gear_average;
  sample_t              battery_average;
  logic                 was_battery_sample;
  logic                 gear_sample_discarded;
  logic                 window_restarted;
  logic                 channel_switched;
  logic                 next_on_battery;

  int          pending;
  int          checked;
  int          errors;
  int unsigned cycle_count = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned gap_pct = 0;
  int unsigned words_sent = 0;
  int unsigned settings_used = 1;
  sample_t     level = 8'd100;
  sample_t     cur_max = MAX_TRANSIENT_RST;

  always #1 clk = ~clk;

  dual_channel_gated_moving_average_unit u_dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .cfg_we_i               (cfg_we),
    .cfg_index_i            (cfg_index),
    .cfg_wdata_i            (cfg_wdata),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .adc_value_i            (adc_value),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .gear_average_o         (gear_average),
    .battery_average_o      (battery_average),
    .was_battery_sample_o   (was_battery_sample),
    .gear_sample_discarded_o(gear_sample_discarded),
    .window_restarted_o     (window_restarted),
    .channel_switched_o     (channel_switched),
    .next_on_battery_o      (next_on_battery)
  );

  dcgma_average_check u_average_check (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .cfg_we_i               (cfg_we),
    .cfg_index_i            (cfg_index),
    .cfg_wdata_i            (cfg_wdata),
    .in_valid_i             (in_valid),
    .in_stall_i             (in_stall),
    .adc_value_i            (adc_value),
    .out_valid_i            (out_valid),
    .out_stall_i            (out_stall),
    .gear_average_i         (gear_average),
    .battery_average_i      (battery_average),
    .was_battery_sample_i   (was_battery_sample),
    .gear_sample_discarded_i(gear_sample_discarded),
    .window_restarted_i     (window_restarted),
    .channel_switched_i     (channel_switched),
    .next_on_battery_i      (next_on_battery),
    .pending_o              (pending),
    .checked_o              (checked),
    .errors_o               (errors)
  );

  // Stall the result side in random bursts; stall_left counts the
  // extra cycles of the current burst.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(3, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Kill a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one word and hold it until accepted, then maybe go idle for a
  // burst. Valid stays high into the next call when no gap is taken.
  task automatic send_sample(input sample_t v);
    in_valid  <= 1'b1;
    adc_value <= v;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both registers back to back; the block is idle here.
  task automatic write_settings(input sample_t min_lvl, input sample_t max_dev);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_GEAR_LEVEL;
    cfg_wdata <= min_lvl;
    @(posedge clk);
    cfg_index <= CFG_MAX_TRANSIENT;
    cfg_wdata <= max_dev;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a drifting signal whose steps straddle the transient limit, with a
  // share of full-range noise and rail values to break the pattern.
  function automatic sample_t next_sample();
    int unsigned pick;
    int          span;
    int          t;
    pick = $urandom_range(99, 0);
    if (pick < 8) return sample_t'($urandom);
    if (pick < 12) return pick[0] ? 8'hFF : 8'h00;
    if ($urandom_range(24, 0) == 0) level = sample_t'($urandom);
    span = int'(cur_max) + 4;
    t = int'(level) + int'($urandom_range(2 * span, 0)) - span;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    level = sample_t'(t);
    return level;
  endfunction

  // One phase: settle, reprogram, then stream n random words.
  task automatic run_phase(input sample_t min_lvl, input sample_t max_dev,
                           input int unsigned gaps, input int unsigned stalls,
                           input int unsigned n);
    drain();
    write_settings(min_lvl, max_dev);
    cur_max   = max_dev;
    gap_pct   = gaps;
    stall_pct <= stalls;
    settings_used++;
    repeat (n) send_sample(next_sample());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under reset register values, with light idling.
    gap_pct   = 20;
    stall_pct <= 20;
    foreach (DIRECTED[i]) send_sample(DIRECTED[i]);

    // Register extremes first, then moderate random settings; one phase runs
    // with no idling at all, and so does the final one.
    run_phase(8'd0,   8'd0,   30, 30, 200);
    run_phase(8'd255, 8'd255, 0,  0,  120);
    run_phase(8'd0,   8'd255, 50, 50, 200);
    run_phase(8'd255, 8'd0,   40, 20, 100);
    repeat (3)
      run_phase(sample_t'($urandom_range(60, 5)), sample_t'($urandom_range(40, 0)),
                $urandom_range(40, 10), $urandom_range(40, 10), 280);
    run_phase(MIN_GEAR_LEVEL_RST, MAX_TRANSIENT_RST, 0, 0, 250);

    // Let the last results out, then give the pipeline time to show strays.
    drain();
    repeat (20) @(posedge clk);

    $display("sent %0d samples over %0d register settings, %0d results compared",
             words_sent, settings_used, checked);
    $display("%0d field mismatches, %0d results outstanding", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dcgma_pkg.sv
src/dual_channel_gated_moving_average_unit.sv
dv/dcgma_average_check.sv
dv/dual_channel_gated_moving_average_unit_test.sv
